// ----- rtl/core/dstp_pkg.sv -----
// package for the deadline sorted timer pool core
// holds pool sizes, request kind codes, result kind codes, timer state codes; no dependencies
package dstp_pkg;

    localparam int TIMER_COUNT  = 64;
    localparam int TASK_ID_BITS = 8;
    localparam int AW           = $clog2(TIMER_COUNT);

    localparam logic [2:0] K_ALLOC    = 3'd0;
    localparam logic [2:0] K_FREE     = 3'd1;
    localparam logic [2:0] K_SET      = 3'd2;
    localparam logic [2:0] K_SET_PREV = 3'd3;
    localparam logic [2:0] K_SET_DATA = 3'd4;
    localparam logic [2:0] K_TICK     = 3'd5;

    localparam logic [1:0] R_ALLOC  = 2'd0;
    localparam logic [1:0] R_ACK    = 2'd1;
    localparam logic [1:0] R_EXPIRY = 2'd2;
    localparam logic [1:0] R_SWITCH = 2'd3;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_ARMED = 2'd2;

    localparam logic [31:0] NEVER_TIME = 32'hFFFF_FFFF;

    // expiry messages per tick stop at this count
    localparam logic [6:0] MSG_CAP = 7'd63;

    typedef struct packed {
        logic [1:0]              kind;
        logic [5:0]              hdl;
        logic [TASK_ID_BITS-1:0] task_id;
        logic [31:0]             data;
        logic                    status;
        logic                    last;
    } t_result;

endpackage

// ----- rtl/core/deadline_sorted_timer_pool_core.sv -----
// deadline sorted timer pool core: timer memories and a walk sequencer; depends on dstp_pkg
// ignored requests, alloc and set_data need no walk; free or set walks one timer per
// cycle to unlink and one per cycle to insert; tick fires due timers from the head in
// turn and can be held by output stalls; one request at a time, the next is taken
// after the last result leaves
// reset is synchronous; a clearing pass over every timer follows with stall high
module deadline_sorted_timer_pool_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [5:0]  i_handle,
    input  logic [31:0] i_time_value,
    input  logic [7:0]  i_owner_task,
    input  logic [31:0] i_data_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [5:0]  o_result_handle,
    output logic [7:0]  o_result_task,
    output logic [31:0] o_result_data,
    output logic        o_status,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    localparam int AW = dstp_pkg::AW;
    localparam int TC = dstp_pkg::TIMER_COUNT;
    localparam int TB = dstp_pkg::TASK_ID_BITS;
    localparam logic [AW-1:0] LAST_IDX = AW'(TC - 1);

    // sequencer states
    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ALLOC   = 4'd2;  // free head entry available
    localparam logic [3:0] S_RD      = 4'd3;  // addressed entry available
    localparam logic [3:0] S_UNL     = 4'd4;  // unlink walk, entry p available
    localparam logic [3:0] S_ARM     = 4'd5;  // write deadline, read head
    localparam logic [3:0] S_INS_H   = 4'd6;  // head entry available
    localparam logic [3:0] S_INS_W   = 4'd7;  // insert walk, entry nx available
    localparam logic [3:0] S_INS_FIX = 4'd8;  // link predecessor to new timer
    localparam logic [3:0] S_FREE    = 4'd9;
    localparam logic [3:0] S_TK_CHK  = 4'd10; // head entry available, fire or stop
    localparam logic [3:0] S_TK_END  = 4'd11; // flush pending expiry and switch

    // timer memories
    logic [1:0]    m_state [TC];
    logic [31:0]   m_dl    [TC];
    logic [31:0]   m_data  [TC];
    logic [TB-1:0] m_owner [TC];
    logic [AW-1:0] m_link  [TC];

    logic [1:0]    rd_state;
    logic [31:0]   rd_dl;
    logic [31:0]   rd_data;
    logic [TB-1:0] rd_owner;
    logic [AW-1:0] rd_link;

    logic          mr_en;
    logic [AW-1:0] mr_addr;
    logic          mw_state_en, mw_dl_en, mw_data_en, mw_owner_en, mw_link_en;
    logic [AW-1:0] mw_addr, mw_link_addr;
    logic [1:0]    mw_state;
    logic [31:0]   mw_dl, mw_data;
    logic [TB-1:0] mw_owner;
    logic [AW-1:0] mw_link;

    // control registers
    logic [3:0]         r_st, n_st;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [31:0]        r_now, n_now;
    logic [AW-1:0]      r_free_head, n_free_head, r_armed_head, n_armed_head;
    logic [5:0]         r_tsh;
    logic [2:0]         r_kind, n_kind;
    logic [AW-1:0]      r_h, n_h, r_p, n_p, r_nx, n_nx, r_hlink, n_hlink;
    logic [31:0]        r_tv, n_tv, r_when, n_when;
    logic [TB-1:0]      r_own, n_own;
    logic [31:0]        r_dw, n_dw;
    logic               r_sw, n_sw;
    logic [6:0]         r_nres, n_nres;
    logic               r_ovalid, n_ovalid;
    dstp_pkg::t_result  r_res, n_res;
    dstp_pkg::t_result  r_pend, n_pend;
    logic               r_pend_v, n_pend_v;
    logic               out_free;
    logic [3:0]         after_rd;

    assign o_stall     = (r_st != S_IDLE) || r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_result_kind   = r_res.kind;
    assign o_result_handle = r_res.hdl;
    assign o_result_task   = r_res.task_id;
    assign o_result_data   = r_res.data;
    assign o_status        = r_res.status;
    assign o_last          = r_res.last;

    assign out_free = !r_ovalid || !i_stall;
    assign after_rd = (r_kind == dstp_pkg::K_FREE) ? S_FREE : S_ARM;

    // memory access
    always_ff @(posedge i_clk) begin
        if (mr_en) begin
            rd_state <= m_state[mr_addr];
            rd_dl    <= m_dl[mr_addr];
            rd_data  <= m_data[mr_addr];
            rd_owner <= m_owner[mr_addr];
            rd_link  <= m_link[mr_addr];
        end
        if (mw_state_en) m_state[mw_addr] <= mw_state;
        if (mw_dl_en)    m_dl[mw_addr]    <= mw_dl;
        if (mw_data_en)  m_data[mw_addr]  <= mw_data;
        if (mw_owner_en) m_owner[mw_addr] <= mw_owner;
        if (mw_link_en)  m_link[mw_link_addr] <= mw_link;
    end

    function automatic dstp_pkg::t_result mk(input logic [1:0] k, input logic [5:0] h,
                                             input logic s);
        dstp_pkg::t_result r;
        r = '0;
        r.kind = k; r.hdl = h; r.status = s; r.last = 1'b1;
        return r;
    endfunction

    // sequencer
    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_now = r_now; n_free_head = r_free_head;
        n_armed_head = r_armed_head; n_kind = r_kind; n_h = r_h; n_p = r_p; n_nx = r_nx;
        n_tv = r_tv; n_when = r_when; n_own = r_own; n_dw = r_dw; n_hlink = r_hlink;
        n_sw = r_sw; n_nres = r_nres; n_res = r_res; n_pend = r_pend; n_pend_v = r_pend_v;
        n_ovalid = r_ovalid && i_stall;
        mr_en = 1'b0; mr_addr = r_h;
        mw_state_en = 1'b0; mw_dl_en = 1'b0; mw_data_en = 1'b0;
        mw_owner_en = 1'b0; mw_link_en = 1'b0;
        mw_addr = r_h; mw_link_addr = r_h; mw_state = dstp_pkg::ST_IDLE;
        mw_dl = dstp_pkg::NEVER_TIME; mw_data = r_dw; mw_owner = r_own; mw_link = '0;
        case (r_st)
            // clearing pass: free chain, sentinel armed
            S_INIT: begin
                mw_addr = r_cnt; mw_link_addr = r_cnt;
                mw_state_en = 1'b1; mw_link_en = 1'b1;
                mw_link = (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
                if (r_cnt == '0) begin
                    mw_state = dstp_pkg::ST_ARMED; mw_dl_en = 1'b1;
                    mw_owner_en = 1'b1; mw_owner = '0; mw_link = '0;
                end else begin
                    mw_state = dstp_pkg::ST_FREE;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) n_st = S_IDLE;
            end
            // take a request
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_kind = i_kind; n_tv = i_time_value; n_dw = i_data_word;
                    n_own  = i_owner_task[TB-1:0];
                    n_h    = i_handle;
                    case (i_kind)
                        dstp_pkg::K_ALLOC: begin
                            if (r_free_head == '0) begin
                                n_res = mk(dstp_pkg::R_ALLOC, 6'd0, 1'b1);
                                n_ovalid = 1'b1;
                            end else begin
                                n_h = r_free_head; mr_en = 1'b1; mr_addr = r_free_head;
                                n_st = S_ALLOC;
                            end
                        end
                        dstp_pkg::K_FREE, dstp_pkg::K_SET, dstp_pkg::K_SET_PREV,
                        dstp_pkg::K_SET_DATA: begin
                            if (i_handle == 6'd0) begin
                                n_res = mk(dstp_pkg::R_ACK, i_handle, 1'b1);
                                n_ovalid = 1'b1;
                            end else begin
                                mr_en = 1'b1; mr_addr = i_handle; n_st = S_RD;
                            end
                        end
                        dstp_pkg::K_TICK: begin
                            n_now = r_now + 32'd1; n_sw = 1'b0; n_nres = '0;
                            n_pend_v = 1'b0;
                            mr_en = 1'b1; mr_addr = r_armed_head; n_h = r_armed_head;
                            n_st = S_TK_CHK;
                        end
                        default: begin
                            n_res = mk(dstp_pkg::R_ACK, i_handle, 1'b1);
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            // pop the free stack
            S_ALLOC: begin
                n_free_head = rd_link;
                mw_link_en = 1'b1; mw_link = '0;
                mw_state_en = 1'b1; mw_dl_en = 1'b1;
                mw_owner_en = 1'b1; mw_data_en = 1'b1;
                n_res = mk(dstp_pkg::R_ALLOC, r_h, 1'b0);
                n_ovalid = 1'b1; n_st = S_IDLE;
            end
            // addressed timer read back
            S_RD: begin
                n_hlink = rd_link;
                if (rd_state == dstp_pkg::ST_FREE) begin
                    n_res = mk(dstp_pkg::R_ACK, r_h, 1'b1); n_ovalid = 1'b1;
                    n_st = S_IDLE;
                end else if (r_kind == dstp_pkg::K_SET_DATA) begin
                    mw_data_en = 1'b1;
                    n_res = mk(dstp_pkg::R_ACK, r_h, 1'b0); n_ovalid = 1'b1;
                    n_st = S_IDLE;
                end else begin
                    if (r_kind == dstp_pkg::K_SET_PREV && rd_dl != dstp_pkg::NEVER_TIME)
                        n_when = rd_dl + r_tv;
                    else
                        n_when = r_now + r_tv;
                    if (rd_state == dstp_pkg::ST_ARMED) begin
                        if (r_armed_head == r_h) begin
                            n_armed_head = rd_link;
                            n_st = after_rd;
                        end else begin
                            n_p = r_armed_head; mr_en = 1'b1; mr_addr = r_armed_head;
                            n_st = S_UNL;
                        end
                    end else begin
                        n_st = after_rd;
                    end
                end
            end
            // unlink walk, one timer per cycle
            S_UNL: begin
                if (rd_link == r_h) begin
                    mw_link_en = 1'b1; mw_link_addr = r_p; mw_link = r_hlink;
                    n_st = after_rd;
                end else if (rd_link == '0) begin
                    n_st = after_rd;
                end else begin
                    n_p = rd_link; mr_en = 1'b1; mr_addr = rd_link;
                end
            end
            // push onto the free stack
            S_FREE: begin
                mw_state_en = 1'b1; mw_state = dstp_pkg::ST_FREE;
                mw_link_en = 1'b1; mw_link = r_free_head;
                n_free_head = r_h;
                n_res = mk(dstp_pkg::R_ACK, r_h, 1'b0); n_ovalid = 1'b1;
                n_st = S_IDLE;
            end
            // new deadline, armed only when not in the past
            S_ARM: begin
                mw_state_en = 1'b1; mw_dl_en = 1'b1; mw_dl = r_when;
                if (r_now > r_when) begin
                    mw_state = dstp_pkg::ST_IDLE;
                    n_res = mk(dstp_pkg::R_ACK, r_h, 1'b0); n_ovalid = 1'b1;
                    n_st = S_IDLE;
                end else begin
                    mw_state = dstp_pkg::ST_ARMED;
                    mr_en = 1'b1; mr_addr = r_armed_head;
                    n_st = S_INS_H;
                end
            end
            // insert ahead of the head when not later than it
            S_INS_H: begin
                if (r_when <= rd_dl) begin
                    mw_link_en = 1'b1; mw_link = r_armed_head;
                    n_armed_head = r_h;
                    n_res = mk(dstp_pkg::R_ACK, r_h, 1'b0); n_ovalid = 1'b1;
                    n_st = S_IDLE;
                end else begin
                    n_p = r_armed_head; n_nx = rd_link;
                    mr_en = 1'b1; mr_addr = rd_link;
                    n_st = S_INS_W;
                end
            end
            // insert walk, ends at the sentinel at the latest
            S_INS_W: begin
                if (r_when <= rd_dl) begin
                    mw_link_en = 1'b1; mw_link = r_nx;
                    n_st = S_INS_FIX;
                end else begin
                    n_p = r_nx; n_nx = rd_link;
                    mr_en = 1'b1; mr_addr = rd_link;
                end
            end
            S_INS_FIX: begin
                mw_link_en = 1'b1; mw_link_addr = r_p; mw_link = r_h;
                n_res = mk(dstp_pkg::R_ACK, r_h, 1'b0); n_ovalid = 1'b1;
                n_st = S_IDLE;
            end
            // fire the head while due; expiry held back until the next is known
            S_TK_CHK: begin
                if (r_pend_v && !out_free) begin
                    n_st = S_TK_CHK;
                end else if (r_h == '0 || rd_dl > r_now) begin
                    n_st = S_TK_END;
                end else begin
                    n_armed_head = rd_link;
                    mw_link_en = 1'b1; mw_link = '0;
                    mw_state_en = 1'b1; mw_state = dstp_pkg::ST_IDLE;
                    n_h = rd_link; mr_en = 1'b1; mr_addr = rd_link;
                    if (r_h == r_tsh) begin
                        n_sw = 1'b1;
                    end else if (rd_owner != '0 && r_nres < dstp_pkg::MSG_CAP) begin
                        n_nres = r_nres + 7'd1;
                        if (r_pend_v) begin
                            n_res = r_pend; n_ovalid = 1'b1;
                        end
                        n_pend = '0;
                        n_pend.kind = dstp_pkg::R_EXPIRY; n_pend.hdl = r_h;
                        n_pend.task_id = rd_owner; n_pend.data = rd_data;
                        n_pend_v = 1'b1;
                    end
                end
            end
            // last expiry, then the switch request
            S_TK_END: begin
                if (r_pend_v || r_sw) begin
                    if (out_free) begin
                        if (r_pend_v) begin
                            n_res = r_pend; n_res.last = !r_sw; n_ovalid = 1'b1;
                            n_pend_v = 1'b0;
                            if (!r_sw) n_st = S_IDLE;
                        end else begin
                            n_res = mk(dstp_pkg::R_SWITCH, r_tsh, 1'b0); n_ovalid = 1'b1;
                            n_sw = 1'b0; n_st = S_IDLE;
                        end
                    end
                end else begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT; r_cnt <= '0; r_now <= '0; r_free_head <= AW'(1);
            r_armed_head <= '0; r_tsh <= '0; r_ovalid <= 1'b0; r_pend_v <= 1'b0;
            r_sw <= 1'b0; r_nres <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_tsh <= i_cfg_data;
            r_st <= n_st; r_cnt <= n_cnt; r_now <= n_now; r_free_head <= n_free_head;
            r_armed_head <= n_armed_head; r_sw <= n_sw; r_nres <= n_nres;
            r_ovalid <= n_ovalid; r_pend_v <= n_pend_v;
        end
    end

    // request and result data
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_h <= n_h; r_p <= n_p; r_nx <= n_nx; r_tv <= n_tv;
        r_when <= n_when; r_own <= n_own; r_dw <= n_dw; r_hlink <= n_hlink;
        r_res <= n_res; r_pend <= n_pend;
    end

    // assertions
    a_no_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_INIT) |-> o_stall) else $error("request taken during clearing pass");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_res)))
        else $error("result changed under stall");
    a_now_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind == dstp_pkg::K_TICK) |=> (r_now == $past(r_now) + 32'd1))
        else $error("tick did not advance time");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("request taken while a result waits");

endmodule
